>>> hw/rtl/segx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment intersection package
// Coordinate widths, derived datapath widths, item types and a shared helper.
// ----------------------------------------------------------------------------
package segx_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned MulW   = 2 * DiffW;
  localparam int unsigned CrossW = MulW + 1;
  localparam int unsigned ProdW  = DiffW + CrossW;
  localparam int unsigned RemW   = CrossW + 1;
  localparam int unsigned TolW   = 16;

  typedef struct packed {
    logic signed [CoordW-1:0] a_start_x;
    logic signed [CoordW-1:0] a_start_y;
    logic signed [CoordW-1:0] a_end_x;
    logic signed [CoordW-1:0] a_end_y;
    logic signed [CoordW-1:0] b_start_x;
    logic signed [CoordW-1:0] b_start_y;
    logic signed [CoordW-1:0] b_end_x;
    logic signed [CoordW-1:0] b_end_y;
  } seg_in_t;

  typedef struct packed {
    logic                     segments_touch;
    logic                     lines_parallel;
    logic                     point_valid;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
  } seg_out_t;

  // True when the product of a and b is zero or negative.
  function automatic logic prod_nonpos(input logic signed [DiffW-1:0] a,
                                       input logic signed [DiffW-1:0] b);
    return (a == '0) || (b == '0) || (a[DiffW-1] != b[DiffW-1]);
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/segment_intersection.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment intersection
// Pipelined 2D segment intersection test with crossing point.
// ----------------------------------------------------------------------------
// Takes one item per cycle unless the pipeline holds. Five stages form
// differences, products, cross products, flags and magnitudes, then a restoring
// divider retires one quotient bit per stage over the ProdW-bit scaled
// direction, and the last stage applies sign, offset and clamp into the output
// register. The whole pipeline holds while a result waits on the output.
module segment_intersection (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire segx_pkg::seg_in_t in_data_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output segx_pkg::seg_out_t     out_data_o,
  input  wire logic              cfg_we_i,
  input  wire logic [15:0]       cfg_data_i
);
  import segx_pkg::*;

  typedef struct packed {
    logic signed [DiffW-1:0]  ax, ay, bx, by, cx, cy, ex, ey, fx, fy, gx, gy;
    logic [3:0]               bnd;
    logic signed [CoordW-1:0] sx, sy;
  } s1_t;

  typedef struct packed {
    logic signed [MulW-1:0]   m0, m1, m2, m3, m4, m5, m6, m7, m8, m9, m10, m11;
    logic signed [DiffW-1:0]  gx, gy;
    logic [3:0]               bnd;
    logic signed [CoordW-1:0] sx, sy;
  } s2_t;

  typedef struct packed {
    logic signed [CrossW-1:0] c1, c2, c3, c4, den, num;
    logic signed [DiffW-1:0]  gx, gy;
    logic [3:0]               bnd;
    logic signed [CoordW-1:0] sx, sy;
  } s3_t;

  typedef struct packed {
    logic signed [ProdW-1:0]  px, py;
    logic signed [CrossW-1:0] den;
    logic                     touch, par, valid;
    logic signed [CoordW-1:0] sx, sy;
  } s4_t;

  typedef struct packed {
    logic [ProdW-1:0]         nqx, nqy;
    logic [RemW-1:0]          rx, ry;
    logic [CrossW-1:0]        d;
    logic                     negx, negy;
    logic                     touch, par, valid;
    logic signed [CoordW-1:0] sx, sy;
  } dv_t;

  logic [TolW-1:0] tol_q;
  logic            adv;
  logic            s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic [ProdW:0]  dv_v_q;
  logic            out_valid_q;
  s1_t             s1_d, s1_q;
  s2_t             s2_d, s2_q;
  s3_t             s3_d, s3_q;
  s4_t             s4_d, s4_q;
  dv_t             dv_q [0:ProdW];
  dv_t             dv0_d;
  seg_out_t        out_d, out_q;

  function automatic logic near_zero(input logic signed [CrossW-1:0] c,
                                     input logic signed [CrossW-1:0] t);
    return !(c > t) && !(c < -t);
  endfunction

  function automatic logic signed [CrossW-1:0] cross_sub(
      input logic signed [MulW-1:0] p, input logic signed [MulW-1:0] q);
    logic signed [CrossW-1:0] pe, qe;
    pe = {p[MulW-1], p};
    qe = {q[MulW-1], q};
    return pe - qe;
  endfunction

  function automatic dv_t div_step(input dv_t s);
    dv_t             r;
    logic [RemW-1:0] tx, ty, dd;
    logic            gex, gey;
    r   = s;
    dd  = {1'b0, s.d};
    tx  = {s.rx[RemW-2:0], s.nqx[ProdW-1]};
    ty  = {s.ry[RemW-2:0], s.nqy[ProdW-1]};
    gex = (tx >= dd);
    gey = (ty >= dd);
    r.rx  = gex ? tx - dd : tx;
    r.ry  = gey ? ty - dd : ty;
    r.nqx = {s.nqx[ProdW-2:0], gex};
    r.nqy = {s.nqy[ProdW-2:0], gey};
    return r;
  endfunction

  function automatic logic signed [CoordW-1:0] place(
      input logic [ProdW-1:0] q, input logic neg, input logic signed [CoordW-1:0] s);
    logic signed [ProdW:0] sq, v, hi, lo;
    sq = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    v  = sq + (ProdW+1)'(s);
    hi = (ProdW+1)'({1'b0, {(CoordW-1){1'b1}}});
    lo = -hi - (ProdW+1)'(1);
    if (v > hi) begin
      return hi[CoordW-1:0];
    end else if (v < lo) begin
      return lo[CoordW-1:0];
    end
    return v[CoordW-1:0];
  endfunction

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_data_i;
    end
  end

  // Stage 1: differences and bound tests.
  always_comb begin
    logic signed [DiffW-1:0] u1x, u1y, u2x, u2y, v1x, v1y, v2x, v2y;
    u1x = {in_data_i.a_start_x[CoordW-1], in_data_i.a_start_x};
    u1y = {in_data_i.a_start_y[CoordW-1], in_data_i.a_start_y};
    u2x = {in_data_i.a_end_x[CoordW-1], in_data_i.a_end_x};
    u2y = {in_data_i.a_end_y[CoordW-1], in_data_i.a_end_y};
    v1x = {in_data_i.b_start_x[CoordW-1], in_data_i.b_start_x};
    v1y = {in_data_i.b_start_y[CoordW-1], in_data_i.b_start_y};
    v2x = {in_data_i.b_end_x[CoordW-1], in_data_i.b_end_x};
    v2y = {in_data_i.b_end_y[CoordW-1], in_data_i.b_end_y};
    s1_d.ax = u1x - v1x;  s1_d.ay = u1y - v1y;
    s1_d.bx = u2x - v1x;  s1_d.by = u2y - v1y;
    s1_d.cx = u1x - v2x;  s1_d.cy = u1y - v2y;
    s1_d.ex = u2x - v2x;  s1_d.ey = u2y - v2y;
    s1_d.fx = v1x - v2x;  s1_d.fy = v1y - v2y;
    s1_d.gx = u1x - u2x;  s1_d.gy = u1y - u2y;
    s1_d.bnd[0] = prod_nonpos(s1_d.ax, s1_d.cx) && prod_nonpos(s1_d.ay, s1_d.cy);
    s1_d.bnd[1] = prod_nonpos(s1_d.bx, s1_d.ex) && prod_nonpos(s1_d.by, s1_d.ey);
    s1_d.bnd[2] = prod_nonpos(s1_d.ax, s1_d.bx) && prod_nonpos(s1_d.ay, s1_d.by);
    s1_d.bnd[3] = prod_nonpos(s1_d.cx, s1_d.ex) && prod_nonpos(s1_d.cy, s1_d.ey);
    s1_d.sx = in_data_i.a_start_x;
    s1_d.sy = in_data_i.a_start_y;
  end

  // Stage 2: products.
  always_comb begin
    s2_d.m0  = s1_q.ax * s1_q.by;  s2_d.m1  = s1_q.bx * s1_q.ay;
    s2_d.m2  = s1_q.cx * s1_q.ey;  s2_d.m3  = s1_q.ex * s1_q.cy;
    s2_d.m4  = s1_q.fx * s1_q.cy;  s2_d.m5  = s1_q.cx * s1_q.fy;
    s2_d.m6  = s1_q.fx * s1_q.ey;  s2_d.m7  = s1_q.ex * s1_q.fy;
    s2_d.m8  = s1_q.gx * s1_q.fy;  s2_d.m9  = s1_q.gy * s1_q.fx;
    s2_d.m10 = s1_q.ax * s1_q.fy;  s2_d.m11 = s1_q.ay * s1_q.fx;
    s2_d.gx  = s1_q.gx;
    s2_d.gy  = s1_q.gy;
    s2_d.bnd = s1_q.bnd;
    s2_d.sx  = s1_q.sx;
    s2_d.sy  = s1_q.sy;
  end

  // Stage 3: cross products.
  always_comb begin
    s3_d.c1  = cross_sub(s2_q.m0, s2_q.m1);
    s3_d.c2  = cross_sub(s2_q.m2, s2_q.m3);
    s3_d.c3  = cross_sub(s2_q.m4, s2_q.m5);
    s3_d.c4  = cross_sub(s2_q.m6, s2_q.m7);
    s3_d.den = cross_sub(s2_q.m8, s2_q.m9);
    s3_d.num = cross_sub(s2_q.m10, s2_q.m11);
    s3_d.gx  = s2_q.gx;
    s3_d.gy  = s2_q.gy;
    s3_d.bnd = s2_q.bnd;
    s3_d.sx  = s2_q.sx;
    s3_d.sy  = s2_q.sy;
  end

  // Stage 4: flags and scaled direction.
  always_comb begin
    logic signed [CrossW-1:0] t;
    logic signed [DiffW-1:0]  dx, dy;
    logic                     z1, z2, z3, z4, ss_u, ss_v;
    t    = $signed({{(CrossW-TolW){1'b0}}, tol_q});
    dx   = -s3_q.gx;
    dy   = -s3_q.gy;
    z1   = near_zero(s3_q.c1, t);
    z2   = near_zero(s3_q.c2, t);
    z3   = near_zero(s3_q.c3, t);
    z4   = near_zero(s3_q.c4, t);
    ss_u = (s3_q.c3 != '0) && (s3_q.c4 != '0) &&
           (s3_q.c3[CrossW-1] == s3_q.c4[CrossW-1]);
    ss_v = (s3_q.c1 != '0) && (s3_q.c2 != '0) &&
           (s3_q.c1[CrossW-1] == s3_q.c2[CrossW-1]);
    if (!z1 || !z2) begin
      s4_d.touch = !ss_u && !ss_v;
    end else begin
      s4_d.touch = (z3 && s3_q.bnd[0]) || (z4 && s3_q.bnd[1]) ||
                   s3_q.bnd[2] || s3_q.bnd[3];
    end
    s4_d.par   = near_zero(s3_q.den, t);
    s4_d.valid = s4_d.touch && !s4_d.par && (s3_q.den != '0);
    s4_d.px    = dx * s3_q.num;
    s4_d.py    = dy * s3_q.num;
    s4_d.den   = s3_q.den;
    s4_d.sx    = s3_q.sx;
    s4_d.sy    = s3_q.sy;
  end

  // Stage 5: magnitudes into the divider.
  always_comb begin
    dv0_d.nqx   = s4_q.px[ProdW-1] ? ProdW'(-s4_q.px) : ProdW'(s4_q.px);
    dv0_d.nqy   = s4_q.py[ProdW-1] ? ProdW'(-s4_q.py) : ProdW'(s4_q.py);
    dv0_d.rx    = '0;
    dv0_d.ry    = '0;
    dv0_d.d     = s4_q.den[CrossW-1] ? CrossW'(-s4_q.den) : CrossW'(s4_q.den);
    dv0_d.negx  = s4_q.px[ProdW-1] ^ s4_q.den[CrossW-1];
    dv0_d.negy  = s4_q.py[ProdW-1] ^ s4_q.den[CrossW-1];
    dv0_d.touch = s4_q.touch;
    dv0_d.par   = s4_q.par;
    dv0_d.valid = s4_q.valid;
    dv0_d.sx    = s4_q.sx;
    dv0_d.sy    = s4_q.sy;
  end

  // Output: sign, offset, clamp.
  always_comb begin
    out_d.segments_touch = dv_q[ProdW].touch;
    out_d.lines_parallel = dv_q[ProdW].par;
    out_d.point_valid    = dv_q[ProdW].valid;
    if (dv_q[ProdW].valid) begin
      out_d.point_x = place(dv_q[ProdW].nqx, dv_q[ProdW].negx, dv_q[ProdW].sx);
      out_d.point_y = place(dv_q[ProdW].nqy, dv_q[ProdW].negy, dv_q[ProdW].sy);
    end else begin
      out_d.point_x = dv_q[ProdW].sx;
      out_d.point_y = dv_q[ProdW].sy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      dv_v_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_v_q      <= in_valid_i;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      s4_v_q      <= s3_v_q;
      dv_v_q      <= {dv_v_q[ProdW-1:0], s4_v_q};
      out_valid_q <= dv_v_q[ProdW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q     <= s1_d;
      s2_q     <= s2_d;
      s3_q     <= s3_d;
      s4_q     <= s4_d;
      dv_q[0]  <= dv0_d;
      out_q    <= out_d;
    end
  end

  for (genvar k = 0; k < ProdW; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[k+1] <= div_step(dv_q[k]);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_point_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.point_valid |->
      out_data_o.segments_touch && !out_data_o.lines_parallel)
    else $error("point valid without touch or with parallel lines");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while pipeline holds");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_v_q)
    else $error("accepted item missing from first stage");

endmodule
`default_nettype wire

>>> test/segment_intersection_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection testbench
// Drives segment pairs through the pipeline under random bursts, gaps and
// output stalls at several tolerance settings, predicts each result with an
// exact integer model and checks every result in order.
// ----------------------------------------------------------------------------
module testbench;
  import segx_pkg::*;

  localparam int PipeLat = 70;
  localparam int CycleLimit = 400000;

  class crossing_board;
    seg_out_t pending[$];
    int       errors;
    longint   tol;

    function new();
      errors = 0;
      tol = 0;
    endfunction

    function automatic longint cross3(longint p1x, longint p1y, longint p2x, longint p2y,
                                      longint p0x, longint p0y);
      return (p1x - p0x) * (p2y - p0y) - (p2x - p0x) * (p1y - p0y);
    endfunction

    function automatic bit is_flat(longint c);
      return c <= tol && c >= -tol;
    endfunction

    function automatic int sgn(longint c);
      return c < 0 ? -1 : (c == 0 ? 0 : 1);
    endfunction

    function automatic bit nonpos(longint a, longint b);
      return a == 0 || b == 0 || ((a < 0) != (b < 0));
    endfunction

    function automatic bit on_seg(longint px, longint py, longint ax, longint ay,
                                  longint bx, longint by);
      return is_flat(cross3(px, py, ax, ay, bx, by)) && nonpos(ax - px, bx - px) &&
             nonpos(ay - py, by - py);
    endfunction

    function automatic bit strict_side(longint p1x, longint p1y, longint p2x, longint p2y,
                                       longint l1x, longint l1y, longint l2x, longint l2y);
      int s1, s2;
      s1 = sgn(cross3(l1x, l1y, p1x, p1y, l2x, l2y));
      s2 = sgn(cross3(l1x, l1y, p2x, p2y, l2x, l2y));
      return s1 != 0 && s1 == s2;
    endfunction

    function automatic logic signed [CoordW-1:0] place(longint st, longint dir,
                                                       longint num, longint den);
      logic signed [127:0] v;
      v = 128'(st) + (128'(dir) * 128'(num)) / 128'(den);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[CoordW-1:0];
    endfunction

    function void note_item(seg_in_t d);
      longint ux1, uy1, ux2, uy2, vx1, vy1, vx2, vy2, num, den;
      seg_out_t r;
      ux1 = d.a_start_x; uy1 = d.a_start_y; ux2 = d.a_end_x; uy2 = d.a_end_y;
      vx1 = d.b_start_x; vy1 = d.b_start_y; vx2 = d.b_end_x; vy2 = d.b_end_y;
      den = (ux1 - ux2) * (vy1 - vy2) - (uy1 - uy2) * (vx1 - vx2);
      num = (ux1 - vx1) * (vy1 - vy2) - (uy1 - vy1) * (vx1 - vx2);
      if (!is_flat(cross3(ux1, uy1, ux2, uy2, vx1, vy1)) ||
          !is_flat(cross3(ux1, uy1, ux2, uy2, vx2, vy2)))
        r.segments_touch = !strict_side(ux1, uy1, ux2, uy2, vx1, vy1, vx2, vy2) &&
                           !strict_side(vx1, vy1, vx2, vy2, ux1, uy1, ux2, uy2);
      else
        r.segments_touch = on_seg(ux1, uy1, vx1, vy1, vx2, vy2) ||
                           on_seg(ux2, uy2, vx1, vy1, vx2, vy2) ||
                           on_seg(vx1, vy1, ux1, uy1, ux2, uy2) ||
                           on_seg(vx2, vy2, ux1, uy1, ux2, uy2);
      r.lines_parallel = is_flat(den);
      r.point_valid = r.segments_touch && !r.lines_parallel && den != 0;
      r.point_x = d.a_start_x;
      r.point_y = d.a_start_y;
      if (r.point_valid) begin
        r.point_x = place(ux1, ux2 - ux1, num, den);
        r.point_y = place(uy1, uy2 - uy1, num, den);
      end
      pending.push_back(r);
    endfunction

    function void check_result(seg_out_t a);
      seg_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.segments_touch !== e.segments_touch) begin
        $error("segments_touch exp %0d got %0d", e.segments_touch, a.segments_touch);
        errors++;
      end
      if (a.lines_parallel !== e.lines_parallel) begin
        $error("lines_parallel exp %0d got %0d", e.lines_parallel, a.lines_parallel);
        errors++;
      end
      if (a.point_valid !== e.point_valid) begin
        $error("point_valid exp %0d got %0d", e.point_valid, a.point_valid);
        errors++;
      end
      if (a.point_x !== e.point_x) begin
        $error("point_x exp %0d got %0d", e.point_x, a.point_x);
        errors++;
      end
      if (a.point_y !== e.point_y) begin
        $error("point_y exp %0d got %0d", e.point_y, a.point_y);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, out_valid_o, out_ready_i, cfg_we_i;
  logic [15:0] cfg_data_i;
  seg_in_t     in_data_i;
  seg_out_t    out_data_o;
  crossing_board board;
  int          cycles;
  int          burst_left;

  segment_intersection u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_data_o);
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int phase;
    phase = 0;
    forever begin
      @(negedge clk_i);
      phase++;
      if ((phase / 300) % 3 == 0) out_ready_i <= 1'b1;
      else if ((phase / 300) % 3 == 1) out_ready_i <= ($urandom_range(0, 3) != 0);
      else out_ready_i <= ((phase % 7) < 3) || ($urandom_range(0, 4) == 0);
    end
  end

  task automatic drive_pair(seg_in_t d);
    int gap;
    while (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap != 0) in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_item(d);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (PipeLat) @(negedge clk_i);
  endtask

  task automatic set_tolerance(logic [15:0] t);
    cfg_we_i <= 1'b1;
    cfg_data_i <= t;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.tol = longint'(t);
  endtask

  function automatic logic signed [15:0] coord(int span);
    if ($urandom_range(0, 9) == 0) return 16'($urandom());
    return 16'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic seg_in_t rand_pair(int span);
    seg_in_t d;
    int k;
    d = {coord(span), coord(span), coord(span), coord(span),
         coord(span), coord(span), coord(span), coord(span)};
    k = $urandom_range(0, 7);
    if (k == 0) begin
      d.b_start_x = d.a_start_x; d.b_start_y = d.a_start_y;
    end else if (k == 1) begin
      d.b_start_x = d.a_end_x + 16'sd1; d.b_start_y = d.a_end_y + 16'sd1;
      d.b_end_x = d.a_end_x + 16'sd3; d.b_end_y = d.a_end_y + 16'sd3;
      d.a_start_x = d.a_end_x - 16'sd2; d.a_start_y = d.a_end_y - 16'sd2;
    end else if (k == 2) begin
      d.b_end_x = d.b_start_x + (d.a_end_x - d.a_start_x);
      d.b_end_y = d.b_start_y + (d.a_end_y - d.a_start_y);
    end
    return d;
  endfunction

  initial begin
    logic signed [15:0] mx, mn;
    int spans[3];
    board = new();
    cycles = 0;
    burst_left = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    mx = 16'sh7fff;
    mn = 16'sh8000;
    spans = '{64, 2000, 32767};
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    drive_pair({16'sd0, 16'sd0, 16'sd160, 16'sd160, 16'sd0, 16'sd160, 16'sd160, 16'sd0});
    drive_pair({16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd16, 16'sd0, 16'sd32, 16'sd0});
    drive_pair({16'sd0, 16'sd0, 16'sd32, 16'sd0, 16'sd16, 16'sd0, 16'sd48, 16'sd0});
    drive_pair({16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd32, 16'sd0, 16'sd48, 16'sd0});
    drive_pair({16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16, 16'sd16, 16'sd16});
    drive_pair({16'sd0, 16'sd0, 16'sd16, 16'sd16, 16'sd32, 16'sd0, 16'sd48, -16'sd16});
    drive_pair({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    drive_pair({mn, mn, mx, mx, mn, mx, mx, mn});
    drive_pair({mx, mn, mn, mx, mn, mn, mx, mx});
    drive_pair({mn, mn, mx, mn, mn, mx, mx, mx});
    drive_pair({mx, mx, mx, mx, mn, mn, mn, mn});
    drive_pair({mn, 16'sd0, mx, 16'sd1, 16'sd0, mn, 16'sd1, mx});
    drive_pair({16'hffff, 16'hffff, 16'sd1, 16'sd1, 16'sd1, 16'hffff, 16'hffff, 16'sd1});
    drain();
    set_tolerance(16'd100);
    drive_pair({16'sd0, 16'sd0, 16'sd160, 16'sd1, 16'sd0, 16'sd3, 16'sd160, 16'sd2});
    drive_pair({16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd50, 16'sd1, 16'sd150, 16'sd1});
    drive_pair({mn, mn, mx, mx, mn, mx, mx, mn});
    drain();
    for (int p = 0; p < 9; p++) begin
      case (p % 4)
        0: set_tolerance(16'd0);
        1: set_tolerance(16'hffff);
        2: set_tolerance(16'($urandom_range(1, 300)));
        default: set_tolerance(16'($urandom()));
      endcase
      for (int i = 0; i < 150; i++) drive_pair(rand_pair(spans[$urandom_range(0, 2)]));
      drain();
    end
    if (board.pending.size() == 0 && board.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

>>> segment_intersection.f
hw/rtl/segx_pkg.sv
hw/rtl/segment_intersection.sv
test/segment_intersection_tb.sv
